[src/pcm_pkg.sv]
// Package with the word types, default sizes and register codes of the coincidence trigger.
`timescale 1ns / 1ps

package pcm_pkg;

    localparam int NUM_CHANNELS_DEF = 16;
    localparam int RING_DEPTH_DEF   = 64;
    localparam int TIME_BITS_DEF    = 32;

    localparam int CHAN_W    = 4;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_THRESHOLD = 8'd1;

    localparam logic [15:0] WINDOW_LENGTH_RST    = 16'd10;
    localparam logic [15:0] CHARGE_THRESHOLD_RST = 16'd64;

    localparam logic [4:0] MULT_MAX = 5'd31;

    typedef struct packed {
        logic [15:0]       module_id;
        logic [CHAN_W-1:0] pmt_channel;
        logic [31:0]       pulse_time;
        logic [15:0]       pulse_charge;
        logic              end_of_module;
    } pcm_in_t;

    typedef struct packed {
        logic [15:0] result_module_id;
        logic [4:0]  best_multiplicity;
        logic [31:0] trigger_time;
        logic        overflow;
    } pcm_out_t;

    typedef struct packed {
        logic clear;
        logic inc;
        logic dec;
    } pcm_cnt_cmd_t;

endpackage

[src/pcm_ram.sv]
// Generic single-port-write, registered-read synchronous RAM.
`timescale 1ns / 1ps

module pcm_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/pcm_chan_tracker.sv]
// Per-channel pulse counts and the number of channels with pulses in the ring.
`timescale 1ns / 1ps

module pcm_chan_tracker
    import pcm_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int RING_DEPTH   = RING_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pcm_cnt_cmd_t                        cmd,
    input  logic [$clog2(NUM_CHANNELS)-1:0]     idx,
    output logic [$clog2(NUM_CHANNELS+1)-1:0]   distinct
);

    localparam int CNT_W  = $clog2(RING_DEPTH + 1);
    localparam int DIST_W = $clog2(NUM_CHANNELS + 1);

    logic [CNT_W-1:0]  counts_reg  [NUM_CHANNELS];
    logic [CNT_W-1:0]  counts_next [NUM_CHANNELS];
    logic [DIST_W-1:0] distinct_reg;
    logic [DIST_W-1:0] distinct_next;
    logic [CNT_W-1:0]  cnt_sel;

    always_comb
    begin
        cnt_sel       = counts_reg[idx];
        counts_next   = counts_reg;
        distinct_next = distinct_reg;
        priority if (cmd.clear)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                counts_next[i] = '0;
            end
            distinct_next = '0;
        end
        else if (cmd.inc)
        begin
            counts_next[idx] = cnt_sel + CNT_W'(1);
            if (cnt_sel == '0)
            begin
                distinct_next = distinct_reg + DIST_W'(1);
            end
        end
        else if (cmd.dec)
        begin
            if (cnt_sel != '0)
            begin
                counts_next[idx] = cnt_sel - CNT_W'(1);
                if (cnt_sel == CNT_W'(1) && distinct_reg != '0)
                begin
                    distinct_next = distinct_reg - DIST_W'(1);
                end
            end
        end
        else
        begin
            distinct_next = distinct_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                counts_reg[i] <= '0;
            end
            distinct_reg <= '0;
        end
        else
        begin
            counts_reg   <= counts_next;
            distinct_reg <= distinct_next;
        end
    end

    assign distinct = distinct_reg;

endmodule

[src/pmt_coincidence_multiplicity.sv]
// Top level of the sliding-window coincidence multiplicity trigger for one module.
//
//  Channel | Signals                              | Direction | Word
//  --------+--------------------------------------+-----------+----------------
//  pulse   | pulse_valid, pulse_ready, pulse      | in        | pcm_in_t
//  result  | result_valid, result_ready, result   | out       | pcm_out_t
//  cfg     | cfg_valid, cfg_ready, cfg_index/data | in        | index, 16 bits
//
// A pulse below threshold is taken in IDLE alone; a kept pulse goes through SCAN,
// which closes one window per cycle, then PUSH; SCAN is skipped when the ring is
// empty before the push. The single read port of the ring sets that window rate.
// An end-of-module word then passes FLUSH_RD, FLUSH for each open window and DONE.
// Reset clears all control state at once; the ring needs no clearing pass.
// The result waits in an output register while new pulses are taken; only the
// next end-of-module word stalls until that register is free.
`timescale 1ns / 1ps

module pmt_coincidence_multiplicity
    import pcm_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int RING_DEPTH   = RING_DEPTH_DEF,
    parameter int TIME_BITS    = TIME_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pulse_valid,
    output logic                  pulse_ready,
    input  pcm_in_t               pulse,
    output logic                  result_valid,
    input  logic                  result_ready,
    output pcm_out_t              result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int HEAD_W = $clog2(RING_DEPTH);
    localparam int FILL_W = HEAD_W + 1;
    localparam int CIDX_W = $clog2(NUM_CHANNELS);
    localparam int DIST_W = $clog2(NUM_CHANNELS + 1);
    localparam int RW     = TIME_BITS + CHAN_W;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SCAN     = 3'd1;
    localparam logic [2:0] ST_PUSH     = 3'd2;
    localparam logic [2:0] ST_FLUSH_RD = 3'd3;
    localparam logic [2:0] ST_FLUSH    = 3'd4;
    localparam logic [2:0] ST_DONE     = 3'd5;

    logic [2:0]           state_reg, state_next;
    logic [15:0]          window_length_reg, window_length_next;
    logic [15:0]          charge_threshold_reg, charge_threshold_next;
    logic [HEAD_W-1:0]    head_reg, head_next;
    logic [FILL_W-1:0]    fill_reg, fill_next;
    logic [DIST_W-1:0]    best_count_reg, best_count_next;
    logic [TIME_BITS-1:0] best_time_reg, best_time_next;
    logic                 dropped_reg, dropped_next;
    logic                 result_valid_reg, result_valid_next;
    pcm_out_t             result_reg, result_next;

    logic [15:0]          cur_module_reg, cur_module_next;
    logic [CHAN_W-1:0]    cur_ch_reg, cur_ch_next;
    logic [TIME_BITS-1:0] cur_time_reg, cur_time_next;
    logic                 cur_eom_reg, cur_eom_next;

    logic                 ram_we;
    logic [HEAD_W-1:0]    ram_waddr;
    logic [HEAD_W-1:0]    ram_raddr;
    logic [RW-1:0]        ram_wdata;
    logic [RW-1:0]        ram_rdata;
    logic [TIME_BITS-1:0] q_time;
    logic [CHAN_W-1:0]    q_ch;

    pcm_cnt_cmd_t         cnt_cmd;
    logic [CIDX_W-1:0]    cnt_idx;
    logic [DIST_W-1:0]    distinct;

    logic                 pulse_acc;
    logic                 kept;
    logic                 close_hit;
    logic [DIST_W-1:0]    mult;
    logic                 result_free;

    pcm_ram #(
        .WIDTH (RW),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pcm_chan_tracker #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .RING_DEPTH   (RING_DEPTH)
    ) u_tracker (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cnt_cmd),
        .idx      (cnt_idx),
        .distinct (distinct)
    );

    assign pulse_ready  = (state_reg == ST_IDLE);
    assign pulse_acc    = pulse_valid && pulse_ready;
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign result_free  = !result_valid_reg || result_ready;

    assign kept = (pulse.pulse_charge >= charge_threshold_reg) &&
                  (32'(pulse.pmt_channel) < 32'(NUM_CHANNELS));

    assign q_time    = ram_rdata[RW-1:CHAN_W];
    assign q_ch      = ram_rdata[CHAN_W-1:0];
    assign close_hit = (cur_time_reg >= q_time) &&
                       ((cur_time_reg - q_time) >= TIME_BITS'(window_length_reg));
    assign mult      = (window_length_reg == '0) ? '0 : distinct;

    assign ram_wdata = {cur_time_reg, cur_ch_reg};
    assign ram_waddr = head_reg + fill_reg[HEAD_W-1:0];

    always_comb
    begin
        window_length_next    = window_length_reg;
        charge_threshold_next = charge_threshold_reg;
        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_WINDOW_LENGTH)
            begin
                window_length_next = cfg_data;
            end
            else if (cfg_index == CFG_CHARGE_THRESHOLD)
            begin
                charge_threshold_next = cfg_data;
            end
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        head_next         = head_reg;
        fill_next         = fill_reg;
        best_count_next   = best_count_reg;
        best_time_next    = best_time_reg;
        dropped_next      = dropped_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;
        cur_module_next   = cur_module_reg;
        cur_ch_next       = cur_ch_reg;
        cur_time_next     = cur_time_reg;
        cur_eom_next      = cur_eom_reg;
        ram_we            = 1'b0;
        ram_raddr         = head_reg;
        cnt_cmd           = '0;
        cnt_idx           = CIDX_W'(q_ch);

        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (pulse_acc)
                begin
                    cur_module_next = pulse.module_id;
                    cur_ch_next     = pulse.pmt_channel;
                    cur_time_next   = TIME_BITS'(pulse.pulse_time);
                    cur_eom_next    = pulse.end_of_module;
                    if (kept)
                    begin
                        state_next = (fill_reg != '0) ? ST_SCAN : ST_PUSH;
                    end
                    else if (pulse.end_of_module)
                    begin
                        state_next = ST_FLUSH_RD;
                    end
                end
            end
            ST_SCAN:
            begin
                if (close_hit)
                begin
                    if (mult > best_count_reg)
                    begin
                        best_count_next = mult;
                        best_time_next  = q_time;
                    end
                    cnt_cmd.dec = 1'b1;
                    head_next   = head_reg + HEAD_W'(1);
                    fill_next   = fill_reg - FILL_W'(1);
                    ram_raddr   = head_reg + HEAD_W'(1);
                    if (fill_reg == FILL_W'(1))
                    begin
                        state_next = ST_PUSH;
                    end
                end
                else
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                cnt_idx = CIDX_W'(cur_ch_reg);
                if (fill_reg == FILL_W'(RING_DEPTH))
                begin
                    dropped_next = 1'b1;
                end
                else
                begin
                    ram_we      = 1'b1;
                    cnt_cmd.inc = 1'b1;
                    fill_next   = fill_reg + FILL_W'(1);
                end
                state_next = cur_eom_reg ? ST_FLUSH_RD : ST_IDLE;
            end
            ST_FLUSH_RD:
            begin
                state_next = (fill_reg != '0) ? ST_FLUSH : ST_DONE;
            end
            ST_FLUSH:
            begin
                if (mult > best_count_reg)
                begin
                    best_count_next = mult;
                    best_time_next  = q_time;
                end
                cnt_cmd.dec = 1'b1;
                head_next   = head_reg + HEAD_W'(1);
                fill_next   = fill_reg - FILL_W'(1);
                ram_raddr   = head_reg + HEAD_W'(1);
                if (fill_reg == FILL_W'(1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (result_free)
                begin
                    result_next.result_module_id  = cur_module_reg;
                    result_next.best_multiplicity =
                        (32'(best_count_reg) > 32'(MULT_MAX)) ? MULT_MAX
                                                              : 5'(best_count_reg);
                    result_next.trigger_time =
                        (best_count_reg == '0) ? 32'd0 : 32'(best_time_reg);
                    result_next.overflow = dropped_reg;
                    result_valid_next    = 1'b1;
                    cnt_cmd.clear        = 1'b1;
                    head_next            = '0;
                    fill_next            = '0;
                    best_count_next      = '0;
                    best_time_next       = '0;
                    dropped_next         = 1'b0;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= ST_IDLE;
            window_length_reg    <= WINDOW_LENGTH_RST;
            charge_threshold_reg <= CHARGE_THRESHOLD_RST;
            head_reg             <= '0;
            fill_reg             <= '0;
            best_count_reg       <= '0;
            best_time_reg        <= '0;
            dropped_reg          <= 1'b0;
            result_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg            <= state_next;
            window_length_reg    <= window_length_next;
            charge_threshold_reg <= charge_threshold_next;
            head_reg             <= head_next;
            fill_reg             <= fill_next;
            best_count_reg       <= best_count_next;
            best_time_reg        <= best_time_next;
            dropped_reg          <= dropped_next;
            result_valid_reg     <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg     <= result_next;
        cur_module_reg <= cur_module_next;
        cur_ch_reg     <= cur_ch_next;
        cur_time_reg   <= cur_time_next;
        cur_eom_reg    <= cur_eom_next;
    end

`ifndef SYNTH
    // The ring never holds more pulses than it has entries.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) <= 32'(RING_DEPTH))
        else $error("ring fill exceeds depth");

    // A window is only examined while the ring holds at least one pulse.
    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN || state_reg == ST_FLUSH) |-> fill_reg != '0)
        else $error("window examined with empty ring");

    // Distinct channels can never outnumber the pulses in the ring.
    a_distinct_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(distinct) <= 32'(fill_reg))
        else $error("distinct channel count exceeds ring fill");

    // A new result appears only as the flush of a module completes.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result raised outside module completion");
`endif

endmodule
